>>> src/lru_buffer_slot_table_macros.svh
// ---------------------------------------------------------------------------
// LRU buffer slot table - assertion macros
// Assertion forms used by the slot table top level.
// ---------------------------------------------------------------------------
`ifndef LRU_BUFFER_SLOT_TABLE_MACROS_SVH
`define LRU_BUFFER_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LBST_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbst: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define LBST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbst: next-cycle check failed");

`endif

>>> src/lbst_pkg.sv
// ---------------------------------------------------------------------------
// LRU buffer slot table - shared package
// Widths, command and status codes, and the control/status structs that
// join the controller and the datapath.
// ---------------------------------------------------------------------------
package lbst_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int HANDLE_W   = 64;
   localparam int GEN_W      = 32;
   localparam int SLOT_REQ_W = 8;
   localparam int SLOT_W     = 3;
   localparam int STATUS_W   = 3;

   localparam logic [GEN_W-1:0] GEN_RESET = 32'd1;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_LOOKUP   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FREE     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_VALID    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OBSOLETE = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                capture;    // take the request fields, start the first read
      logic                step;       // read the next stored handle
      logic                insert;     // write the handle, update fill count and recency
      logic                res_load;   // latch the result with res_status
      logic [STATUS_W-1:0] res_status;
      logic                emit;       // move the result into the output register
   } lbst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_lookup;
      logic handle_zero;
      logic lookup_ok;
      logic hit;
      logic more;
      logic full;
      logic rsp_free;
   } lbst_stat_type;

endpackage

>>> src/lbst_ctrl.sv
// ---------------------------------------------------------------------------
// LRU buffer slot table - controller
// Sequences one request: capture, a scan or a single slot read, result.
// ---------------------------------------------------------------------------
module lbst_ctrl import lbst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  lbst_stat_type stat,
   output lbst_cmd_type  cmd
);

   typedef enum logic [2:0] {
      STATE_IDLE = 3'b001,
      STATE_SCAN = 3'b010,
      STATE_EMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == STATE_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = STATE_SCAN;
            end
         end
         STATE_SCAN: begin
            if (stat.is_lookup) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = stat.lookup_ok ? ST_VALID : ST_OBSOLETE;
               state_in       = STATE_EMIT;
            end else if (stat.handle_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OBSOLETE;
               state_in       = STATE_EMIT;
            end else if (stat.hit) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_PRESENT;
               state_in       = STATE_EMIT;
            end else if (stat.more) begin
               cmd.step = 1'b1;
            end else begin
               cmd.insert     = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = stat.full ? ST_EVICT : ST_FREE;
               state_in       = STATE_EMIT;
            end
         end
         STATE_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/lbst_dpath.sv
// ---------------------------------------------------------------------------
// LRU buffer slot table - datapath
// Handle memory, fill count, recency list, generation register and the
// result and output registers.
// ---------------------------------------------------------------------------
module lbst_dpath import lbst_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_command,
   input  logic        [HANDLE_W-1:0]   req_handle,
   input  logic signed [SLOT_REQ_W-1:0] req_slot_request,
   input  logic        [GEN_W-1:0]      req_request_generation,
   input  logic                         csr_write_enable,
   input  logic        [GEN_W-1:0]      csr_write_data,
   input  lbst_cmd_type                 cmd,
   output lbst_stat_type                stat,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [SLOT_W-1:0]     rsp_slot,
   output logic        [HANDLE_W-1:0]   rsp_stored_handle,
   output logic        [STATUS_W-1:0]   rsp_status
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = IW + 1;

   // Captured request.
   logic                  command_ff,  command_in;
   logic [HANDLE_W-1:0]   handle_ff,   handle_in;
   logic [SLOT_REQ_W-1:0] slot_req_ff, slot_req_in;
   logic [GEN_W-1:0]      req_gen_ff,  req_gen_in;

   logic [GEN_W-1:0]      gen_ff,        gen_in;
   logic [CW-1:0]         fill_count_ff, fill_count_in;
   logic [IW-1:0]         scan_idx_ff,   scan_idx_in;

   logic [HANDLE_W-1:0]   mem [SLOTS];
   logic [HANDLE_W-1:0]   rd_data_ff;
   logic [IW-1:0]         rd_addr;
   logic                  rd_en;
   logic [IW-1:0]         recency_ff [SLOTS];

   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [SLOT_W-1:0]     res_slot_ff,   res_slot_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;

   logic                  rsp_valid_ff,  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff,   rsp_slot_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;

   logic [IW-1:0]         scan_next;
   logic [IW-1:0]         target;
   logic [IW+2:0]         scan_wide;
   logic [IW+2:0]         target_wide;
   logic [SLOT_REQ_W-1:0] fill_wide;
   logic                  in_fill;
   logic                  full;

   assign scan_next   = scan_idx_ff + 1'b1;
   assign full        = (fill_count_ff == CW'(SLOTS));
   assign target      = full ? recency_ff[SLOTS-1] : fill_count_ff[IW-1:0];
   assign scan_wide   = {3'b000, scan_idx_ff};
   assign target_wide = {3'b000, target};
   assign fill_wide   = {{(SLOT_REQ_W-CW){1'b0}}, fill_count_ff};
   assign in_fill     = ({1'b0, scan_idx_ff} < fill_count_ff);

   // Occupied slots always form the range below the fill count.
   always_comb begin
      stat.is_lookup   = (command_ff == CMD_LOOKUP);
      stat.handle_zero = (handle_ff == '0);
      stat.lookup_ok   = !slot_req_ff[SLOT_REQ_W-1] && (slot_req_ff < fill_wide)
                         && (req_gen_ff == gen_ff);
      stat.hit         = in_fill && (rd_data_ff == handle_ff);
      stat.more        = (({1'b0, scan_idx_ff} + CW'(1)) < fill_count_ff);
      stat.full        = full;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      command_in  = cmd.capture ? req_command            : command_ff;
      handle_in   = cmd.capture ? req_handle             : handle_ff;
      slot_req_in = cmd.capture ? req_slot_request       : slot_req_ff;
      req_gen_in  = cmd.capture ? req_request_generation : req_gen_ff;
      gen_in      = csr_write_enable ? csr_write_data : gen_ff;

      fill_count_in = fill_count_ff;
      if (cmd.insert && !full) begin
         fill_count_in = fill_count_ff + CW'(1);
      end

      scan_idx_in = scan_idx_ff;
      if (cmd.capture) begin
         scan_idx_in = '0;
      end else if (cmd.step) begin
         scan_idx_in = scan_next;
      end

      rd_en = cmd.capture || cmd.step;
      if (cmd.capture) begin
         rd_addr = (req_command == CMD_LOOKUP) ? req_slot_request[IW-1:0] : '0;
      end else begin
         rd_addr = scan_next;
      end
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_handle_in = res_handle_ff;
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         case (cmd.res_status)
            ST_PRESENT: begin
               res_slot_in   = scan_wide[SLOT_W-1:0];
               res_handle_in = '0;
            end
            ST_FREE, ST_EVICT: begin
               res_slot_in   = target_wide[SLOT_W-1:0];
               res_handle_in = '0;
            end
            ST_VALID: begin
               res_slot_in   = slot_req_ff[SLOT_W-1:0];
               res_handle_in = rd_data_ff;
            end
            default: begin
               res_slot_in   = '0;
               res_handle_in = '0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_handle_in = res_handle_ff;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end else begin
         rsp_valid_in  = rsp_valid_ff;
      end
   end

   // Handle memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         mem[target] <= handle_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Recency list, most recent first. A new or evicted slot always enters
   // at the front and the tail drops off.
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         recency_ff[0] <= target;
         for (int i = 1; i < SLOTS; i++) begin
            recency_ff[i] <= recency_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      command_ff    <= command_in;
      handle_ff     <= handle_in;
      slot_req_ff   <= slot_req_in;
      req_gen_ff    <= req_gen_in;
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff        <= GEN_RESET;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         gen_ff        <= gen_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_stored_handle = rsp_handle_ff;

endmodule

>>> src/lru_buffer_slot_table.sv
// ---------------------------------------------------------------------------
// LRU buffer slot table - top level
// Maps nonzero 64-bit buffer handles to slot numbers with least recently
// filled replacement, and validates slot lookups against a generation.
// ---------------------------------------------------------------------------
// The table holds SLOTS handles and works on one request at a time. A
// register request scans the stored handles one per cycle through the
// single read port of the handle memory, stopping at the first match; only
// occupied slots are scanned, because slots fill from zero upwards and are
// never emptied, so a fill count stands in for per-slot valid bits and no
// clearing pass is needed after reset. An empty table, a zero handle or a
// match in slot 0 ends a register request on its first read; a miss ends it
// after the last occupied slot and writes the new handle. A lookup reads
// only the requested slot. The result is latched in the result register
// and then moved into the output register. The next request is taken in
// the cycle after the result enters the output register; a result that is
// not taken holds the block in that last step until the output register
// frees. The current generation, which resets to one, is written through
// the csr port by the user while the block is idle (not enforced).
// ---------------------------------------------------------------------------
`include "lru_buffer_slot_table_macros.svh"

module lru_buffer_slot_table import lbst_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic        [HANDLE_W-1:0]   req_handle,
   input  logic signed [SLOT_REQ_W-1:0] req_slot_request,
   input  logic        [GEN_W-1:0]      req_request_generation,

   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [SLOT_W-1:0]     rsp_slot,
   output logic        [HANDLE_W-1:0]   rsp_stored_handle,
   output logic        [STATUS_W-1:0]   rsp_status,

   // Current generation register.
   input  logic                         csr_write_enable,
   input  logic        [GEN_W-1:0]      csr_write_data
);

   lbst_cmd_type  cmd;
   lbst_stat_type stat;

   // The controller decides each step from the datapath status; the
   // datapath owns every stored value.
   lbst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lbst_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .req_command            (req_command),
      .req_handle             (req_handle),
      .req_slot_request       (req_slot_request),
      .req_request_generation (req_request_generation),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data),
      .cmd                    (cmd),
      .stat                   (stat),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_slot               (rsp_slot),
      .rsp_stored_handle      (rsp_stored_handle),
      .rsp_status             (rsp_status)
   );

   // A presented result always carries one of the five defined status codes,
   // which run contiguously from zero.
   `LBST_ASSERT_IMPLY(a_status_legal, clock, reset, rsp_valid, rsp_status <= ST_OBSOLETE)

   // Only a valid lookup returns a handle.
   `LBST_ASSERT_IMPLY(a_handle_only_on_valid, clock, reset, rsp_valid && (rsp_status != ST_VALID), rsp_stored_handle == '0)

   // One request at a time: after a transfer in, the block is busy.
   `LBST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // The table is written only for a register request with a nonzero handle.
   `LBST_ASSERT_IMPLY(a_insert_on_register, clock, reset, cmd.insert, !stat.is_lookup && !stat.handle_zero)

endmodule

>>> sim/tb_lru_buffer_slot_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the LRU buffer slot table
// Drives register and lookup requests through the valid/ready request port
// and checks every response, field by field and in order, against a
// behavioural copy of the slot table kept inside the bench.
// ---------------------------------------------------------------------------
module tb_lru_buffer_slot_table import lbst_pkg::*; ();

   localparam int N_SLOTS        = SLOTS_DEFAULT;
   localparam int POOL_N         = 12;     // a few more handles than slots, so evictions occur
   localparam int RAND_PER_PHASE = 232;
   localparam int SETTLE_CYCLES  = N_SLOTS + 6;
   localparam int QUIET_LIMIT    = 2000;   // cycles without any transfer before giving up

   typedef struct packed {
      logic                         command;
      logic        [HANDLE_W-1:0]   handle;
      logic signed [SLOT_REQ_W-1:0] slot_request;
      logic        [GEN_W-1:0]      generation;
   } slot_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] stored_handle;
      logic [STATUS_W-1:0] status;
   } slot_rsp_type;

   // One row of the directed table. Where fixed is set, want holds the
   // response typed in by hand; otherwise the table model supplies it.
   typedef struct packed {
      slot_req_type rq;
      logic         fixed;
      slot_rsp_type want;
   } dir_row_type;

   // Clock, reset and every DUT input start at known values.
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = CMD_REGISTER;
   logic        [HANDLE_W-1:0]   req_handle = '0;
   logic signed [SLOT_REQ_W-1:0] req_slot_request = '0;
   logic        [GEN_W-1:0]      req_request_generation = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic        [SLOT_W-1:0]     rsp_slot;
   logic        [HANDLE_W-1:0]   rsp_stored_handle;
   logic        [STATUS_W-1:0]   rsp_status;
   logic                         csr_write_enable = 1'b0;
   logic        [GEN_W-1:0]      csr_write_data = '0;

   // Behavioural copy of the table: the handle held in each slot (zero for
   // empty), the recency list with the most recently filled slot first, and
   // the current generation register.
   logic [HANDLE_W-1:0] tbl_handle [N_SLOTS];
   int                  mru_list [N_SLOTS];
   int                  mru_len = 0;
   logic [GEN_W-1:0]    cur_gen = GEN_RESET;

   slot_rsp_type        pending_rsp [$];
   dir_row_type         dir_rows [$];
   logic [HANDLE_W-1:0] handle_pool [POOL_N];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   lru_buffer_slot_table dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_command            (req_command),
      .req_handle             (req_handle),
      .req_slot_request       (req_slot_request),
      .req_request_generation (req_request_generation),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_slot               (rsp_slot),
      .rsp_stored_handle      (rsp_stored_handle),
      .rsp_status             (rsp_status),
      .csr_write_enable       (csr_write_enable),
      .csr_write_data         (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the response to one request and updates the table copy in
   // the same way the block should. A register of a handle already held
   // leaves the recency list alone; a new handle takes the lowest empty slot
   // or, with the table full, the slot at the tail of the recency list.
   function automatic slot_rsp_type table_predict(input slot_req_type rq);
      slot_rsp_type r;
      int           target;
      int           pos;
      int           idx;
      r = '{slot: '0, stored_handle: '0, status: ST_OBSOLETE};
      if (rq.command == CMD_REGISTER) begin
         // A zero handle is refused and changes nothing.
         if (rq.handle == '0) begin
            return r;
         end
         target = -1;
         for (int i = 0; i < N_SLOTS; i++) begin
            if (tbl_handle[i] == rq.handle) begin
               r.slot   = SLOT_W'(i);
               r.status = ST_PRESENT;
               return r;
            end
            if (tbl_handle[i] == '0 && target < 0) begin
               target = i;
            end
         end
         r.status = ST_FREE;
         if (target < 0) begin
            target = (mru_len == N_SLOTS) ? mru_list[N_SLOTS-1] : 0;
            if (target >= N_SLOTS || target < 0) begin
               target = 0;
            end
            r.status = ST_EVICT;
         end
         tbl_handle[target] = rq.handle;
         // Move the slot to the front of the recency list.
         pos = mru_len;
         for (int i = 0; i < mru_len; i++) begin
            if (mru_list[i] == target) begin
               pos = i;
               break;
            end
         end
         if (pos >= N_SLOTS) begin
            pos = N_SLOTS - 1;
         end
         if (pos == mru_len && mru_len < N_SLOTS) begin
            mru_len++;
         end
         for (int i = pos; i > 0; i--) begin
            mru_list[i] = mru_list[i-1];
         end
         mru_list[0] = target;
         r.slot = SLOT_W'(target);
      end else begin
         // A lookup is good only for a non-negative slot in range, with the
         // current generation, naming an occupied slot.
         idx = int'($unsigned(rq.slot_request));
         if (idx < 128 && idx < N_SLOTS && rq.generation == cur_gen &&
             tbl_handle[idx] != '0) begin
            r.slot          = SLOT_W'(idx);
            r.stored_handle = tbl_handle[idx];
            r.status        = ST_VALID;
         end
      end
      return r;
   endfunction

   function automatic void add_row(input logic cmd, input logic [HANDLE_W-1:0] h,
                                   input logic signed [SLOT_REQ_W-1:0] s,
                                   input logic [GEN_W-1:0] g, input logic fixed,
                                   input logic [SLOT_W-1:0] w_slot,
                                   input logic [HANDLE_W-1:0] w_handle,
                                   input logic [STATUS_W-1:0] w_status);
      dir_row_type row;
      row.rq   = '{command: cmd, handle: h, slot_request: s, generation: g};
      row.fixed = fixed;
      row.want = '{slot: w_slot, stored_handle: w_handle, status: w_status};
      dir_rows.push_back(row);
   endfunction

   // Random traffic is mostly well-formed: registers draw from a small pool
   // of handles so that hits and evictions both happen, and lookups mostly
   // ask for an in-range slot with the current generation. The remainder is
   // zero handles, fresh handles, wrong generations and arbitrary slot ids.
   function automatic slot_req_type random_request();
      slot_req_type rq;
      int           pick;
      rq.command      = ($urandom_range(0, 99) < 55) ? CMD_REGISTER : CMD_LOOKUP;
      rq.handle       = {$urandom, $urandom};
      rq.slot_request = SLOT_REQ_W'($urandom);
      rq.generation   = $urandom;
      pick = $urandom_range(0, 99);
      if (rq.command == CMD_REGISTER) begin
         if (pick < 6) begin
            rq.handle = '0;
         end else if (pick < 72) begin
            rq.handle = handle_pool[$urandom_range(0, POOL_N - 1)];
         end
      end else begin
         if (pick < 72) begin
            rq.slot_request = SLOT_REQ_W'($urandom_range(0, N_SLOTS - 1));
            rq.generation   = cur_gen;
         end else if (pick < 84) begin
            rq.generation = cur_gen;
         end else if (pick < 92) begin
            rq.slot_request = SLOT_REQ_W'($urandom_range(0, N_SLOTS - 1));
            rq.generation   = cur_gen ^ (GEN_W'(1) << $urandom_range(0, GEN_W - 1));
         end
      end
      return rq;
   endfunction

   task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
                                  input logic [HANDLE_W-1:0] want);
      error_count++;
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Presents one request and returns at the edge where it is transferred.
   // Valid is only lowered for an idle gap, so a back-to-back request never
   // sees valid dropped and raised within the same step.
   task automatic send_request(input slot_req_type rq);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_command            <= rq.command;
      req_handle             <= rq.handle;
      req_slot_request       <= rq.slot_request;
      req_request_generation <= rq.generation;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the request side quiet until every outstanding response has
   // come back. Called at the edge of the last request transfer.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Only ever called with the block idle.
   task automatic write_generation(input logic [GEN_W-1:0] g);
      csr_write_enable <= 1'b1;
      csr_write_data   <= g;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_gen = g;
   endtask

   // The response side stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Response checker. Values are read straight after the edge, before any
   // nonblocking update of that edge lands, so they are the ones that took
   // part in the transfer.
   always @(posedge clock) begin
      slot_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with none outstanding", rsp_stored_handle, '0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_slot !== want.slot) begin
               report_mismatch("slot", HANDLE_W'(rsp_slot), HANDLE_W'(want.slot));
            end
            if (rsp_stored_handle !== want.stored_handle) begin
               report_mismatch("stored_handle", rsp_stored_handle, want.stored_handle);
            end
            if (rsp_status !== want.status) begin
               report_mismatch("status", HANDLE_W'(rsp_status), HANDLE_W'(want.status));
            end
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count, so a hung
   // handshake ends the run rather than leaving it spinning.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb_lru_buffer_slot_table: done, errors");
         $finish;
      end
   end

   initial begin
      slot_rsp_type predicted;
      slot_req_type rq;
      logic [GEN_W-1:0] phase_gen [4];
      int phase_idle [4];
      int phase_stall [4];

      for (int i = 0; i < N_SLOTS; i++) begin
         tbl_handle[i] = '0;
         mru_list[i]   = 0;
      end
      for (int i = 0; i < POOL_N; i++) begin
         handle_pool[i] = {$urandom, $urandom} | HANDLE_W'(1);
      end

      // Directed table, run with the generation still at its reset value of
      // one. The first rows probe the empty table and the refused zero
      // handle, then the all-ones handle goes in and is looked up from every
      // angle: wrong generation, slot ids below zero, past the end and at the
      // signed extremes, and an empty slot. The table is then filled, the
      // least recently filled slot is evicted, and a re-register of a held
      // handle is shown not to disturb the recency order.
      add_row(CMD_LOOKUP,   64'h0,                  8'sd0,    32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_REGISTER, 64'h0,                  8'sh7f,   32'hffff_ffff, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_REGISTER, 64'hffff_ffff_ffff_ffff, 8'sh80,  32'd0, 1'b1,
              3'd0, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'hffff_ffff_ffff_ffff, 8'sd3,   32'd1, 1'b1,
              3'd0, 64'h0, ST_PRESENT);
      add_row(CMD_LOOKUP,   64'hdead_beef_0bad_f00d, 8'sd0,   32'd1, 1'b1,
              3'd0, 64'hffff_ffff_ffff_ffff, ST_VALID);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd0,    32'd0, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd0,    32'hffff_ffff, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sh80,   32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sh7f,   32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd8,    32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  -8'sd1,   32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd7,    32'd1, 1'b1,
              3'd0, 64'h0, ST_OBSOLETE);
      add_row(CMD_REGISTER, 64'h0000_0000_0000_0001, 8'sd0,   32'd0, 1'b1,
              3'd1, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'h8000_0000_0000_0000, 8'sd0,   32'd0, 1'b1,
              3'd2, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'h5555_5555_5555_5555, 8'sd0,   32'd0, 1'b1,
              3'd3, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'haaaa_aaaa_aaaa_aaaa, 8'sd0,   32'd0, 1'b1,
              3'd4, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'h0123_4567_89ab_cdef, 8'sd0,   32'd0, 1'b1,
              3'd5, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'hffff_ffff_0000_0000, 8'sd0,   32'd0, 1'b1,
              3'd6, 64'h0, ST_FREE);
      add_row(CMD_REGISTER, 64'h0000_0000_ffff_ffff, 8'sd0,   32'd0, 1'b1,
              3'd7, 64'h0, ST_FREE);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd7,    32'd1, 1'b1,
              3'd7, 64'h0000_0000_ffff_ffff, ST_VALID);
      add_row(CMD_REGISTER, 64'h0000_0000_0000_0002, 8'sd0,   32'd0, 1'b1,
              3'd0, 64'h0, ST_EVICT);
      add_row(CMD_REGISTER, 64'h0000_0000_0000_0001, 8'sd0,   32'd0, 1'b1,
              3'd1, 64'h0, ST_PRESENT);
      add_row(CMD_REGISTER, 64'h0000_0000_0000_0003, 8'sd0,   32'd0, 1'b0,
              3'd0, 64'h0, ST_PRESENT);
      add_row(CMD_LOOKUP,   64'h0,                  8'sd0,    32'd1, 1'b0,
              3'd0, 64'h0, ST_PRESENT);

      // Idling phases: none, sender only, receiver only, then both.
      phase_gen   = '{32'hffff_ffff, 32'h0000_0000, $urandom, $urandom};
      phase_idle  = '{0, 45, 0, 17};
      phase_stall = '{0, 0, 45, 17};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The table model is still run on hand-checked rows so that its state
      // keeps step with the block.
      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].rq);
         predicted = table_predict(dir_rows[i].rq);
         pending_rsp.push_back(dir_rows[i].fixed ? dir_rows[i].want : predicted);
      end

      for (int ph = 0; ph < 4; ph++) begin
         // The generation register is only written with nothing in flight.
         wait_results_drained();
         write_generation(phase_gen[ph]);
         send_idle_pct = phase_idle[ph];
         rsp_stall_pct = phase_stall[ph];
         for (int k = 0; k < RAND_PER_PHASE; k++) begin
            // Halfway through each phase the sender holds back until every
            // response is in, so the block is seen starting again from idle.
            if (k == RAND_PER_PHASE / 2) begin
               wait_results_drained();
            end
            rq = random_request();
            send_request(rq);
            pending_rsp.push_back(table_predict(rq));
         end
      end

      // Let the last responses come home, then watch a little longer for
      // anything the block should not have sent.
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_lru_buffer_slot_table: done, clean");
      end else begin
         $display("tb_lru_buffer_slot_table: done, errors");
      end
      $finish;
   end

endmodule
